// ----- rtl/ahlc_pkg.sv -----
// Shared widths, reset values, codes and control types of the audio filter chain.
package ahlc_pkg;

    localparam int ACC_W      = 48;            // fast/slow accumulator width (40..64)
    localparam int FRAC       = 16;            // fraction bits of the 16.16 values
    localparam int LO_W       = 32;            // low slice of a difference
    localparam int HI_W       = ACC_W - LO_W;  // signed high slice of a difference
    localparam int SMP_W      = 17;
    localparam int OUT_W      = 16;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 18;
    localparam int MODE_W     = 2;
    localparam int LP_W       = 32;
    localparam int DIFF_W     = LP_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // shared multiplier: signed A x signed B, unsigned operands get a zero sign bit
    localparam int MA_W = LO_W + 1;
    localparam int MB_W = GAIN_W + 1;
    localparam int MP_W = MA_W + MB_W;

    localparam logic [COEF_W-1:0] FAST_COEF_RST = COEF_W'(128);
    localparam logic [COEF_W-1:0] SLOW_COEF_RST = COEF_W'(32);
    localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(98304);
    localparam logic [MODE_W-1:0] LP_MODE_RST   = '0;
    localparam logic [MODE_W-1:0] LP_BYPASS     = '0;

    localparam logic [OUT_W-1:0] Y_MAX = 16'h7FFF;  //  32767
    localparam logic [OUT_W-1:0] Y_MIN = 16'h8000;  // -32768

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_COEF = 2'd0,
        CFG_SLOW_COEF = 2'd1,
        CFG_GAIN      = 2'd2,
        CFG_LP_MODE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MOP_GAIN = 2'd0,   // sample x gain
        MOP_LO   = 2'd1,   // low slice of difference x coefficient
        MOP_HI   = 2'd2    // high slice of difference x coefficient
    } t_mop;

    typedef struct packed {
        logic mul_en;
        t_mop mop;
        logic coef_slow;   // slow pole operand and accumulator
        logic d1;          // scaled sample in, first difference
        logic t_ino_slow;  // scratch <= scaled - slow
        logic acc_lo;      // accumulator += low product >> 16
        logic acc_hi;      // accumulator += high product << 16
        logic d2;          // second difference
        logic t_fast_ino;  // scratch <= fast - scaled
        logic sat;         // high-pass sum, shift and clamp
        logic lpd;         // low-pass difference
        logic out_try;     // finish low-pass and load output stage
    } t_ctl;

endpackage

// ----- rtl/ahlc_if.sv -----
// Valid/ready channel interfaces for the sample input and output.
interface ahlc_in_if;
    import ahlc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_in;
    logic                    block_last;

    modport source (output valid, output sample_in, output block_last, input ready);
    modport sink   (input valid, input sample_in, input block_last, output ready);
endinterface

interface ahlc_out_if;
    import ahlc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_out;
    logic                    clipped;
    logic                    last_out;

    modport source (output valid, output sample_out, output clipped, output last_out,
                    input ready);
    modport sink   (input valid, input sample_out, input clipped, input last_out,
                    output ready);
endinterface

// ----- rtl/audio_highpass_lowpass_chain.sv -----
// Top level: DC-blocking high-pass with optional one-pole low-pass, one shared multiplier.
//
//  channel  dir  handshake      payload
//  i_smp    in   valid/ready    sample_in[16:0] signed, block_last
//  o_smp    out  valid/ready    sample_out[15:0] signed, clipped, last_out
//  i_cfg    in   i_cfg_we       i_cfg_idx[1:0], i_cfg_data[17:0]
//
//  Each sample runs through 12 sequencer steps after its transfer, set by the
//  one multiplier doing gain, two slices of the fast pole and two slices of
//  the slow pole in turn.
//  The finished sample sits in an output register; the next transfer is taken
//  while it waits, and the sequencer stalls at its last step only if the
//  previous result has not left yet.
//  Synchronous active-low reset clears the accumulators, loads the register
//  defaults and empties the output stage.
module audio_highpass_lowpass_chain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ahlc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ahlc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ahlc_in_if.sink                             i_smp,
    ahlc_out_if.source                          o_smp
);
    import ahlc_pkg::*;

    // configuration
    logic [COEF_W-1:0] r_fast_coef;
    logic [COEF_W-1:0] r_slow_coef;
    logic [GAIN_W-1:0] r_gain;
    logic [MODE_W-1:0] r_mode;

    // filter state
    logic [ACC_W-1:0] r_fast;
    logic [ACC_W-1:0] r_slow;
    logic [LP_W-1:0]  r_lp;

    // per-sample working registers
    logic [SMP_W-1:0]         r_smp;
    logic                     r_last;
    logic [ACC_W-1:0]         r_ino;   // scaled sample, sign-extended
    logic [ACC_W-1:0]         r_d;     // difference feeding the multiplier
    logic [ACC_W-1:0]         r_t;     // scratch partial sum
    logic [OUT_W-1:0]         r_y;     // saturated high-pass value
    logic                     r_clip;
    logic signed [DIFF_W-1:0] r_diff;  // low-pass target minus state

    // output stage
    logic             r_ov;
    logic [OUT_W-1:0] r_osmp;
    logic             r_oclip;
    logic             r_olast;

    t_ctl                   ctl;
    logic                   w_start;
    logic                   w_out_free;
    logic signed [MA_W-1:0] w_a;
    logic signed [MB_W-1:0] w_b;
    logic signed [MP_W-1:0] w_p;
    logic [ACC_W-1:0]       w_p_acc;
    logic [ACC_W-1:0]       w_acc_cur;
    logic [ACC_W-1:0]       w_acc_inc;
    logic [ACC_W-1:0]       w_acc_new;
    logic [ACC_W-1:0]       w_hp;
    logic [ACC_W-OUT_W-FRAC:0] w_hp_top;
    logic                   w_fits;
    logic signed [DIFF_W-1:0] w_lp_step;
    logic [LP_W-1:0]        w_lp_new;

    assign w_start    = i_smp.valid && i_smp.ready;
    assign w_out_free = !r_ov || o_smp.ready;

    ahlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_ready    (i_smp.ready),
        .o_ctl      (ctl)
    );

    // multiplier operands: sample x gain, or a slice of the difference x pole coefficient
    always_comb begin
        case (ctl.mop)
            MOP_GAIN: w_a = {{(MA_W-SMP_W){r_smp[SMP_W-1]}}, r_smp};
            MOP_LO:   w_a = {1'b0, r_d[LO_W-1:0]};
            MOP_HI:   w_a = {{(MA_W-HI_W){r_d[ACC_W-1]}}, r_d[ACC_W-1:LO_W]};
            default:  w_a = '0;
        endcase
        if (ctl.mop == MOP_GAIN) begin
            w_b = {1'b0, r_gain};
        end else begin
            w_b = {{(MB_W-COEF_W){1'b0}}, (ctl.coef_slow ? r_slow_coef : r_fast_coef)};
        end
    end

    ahlc_mul u_mul (
        .i_clk (i_clk),
        .i_en  (ctl.mul_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    assign w_p_acc = ACC_W'(w_p);

    // floor(d * c / 2^16) in two parts: unsigned low slice, then signed high slice
    assign w_acc_cur = ctl.coef_slow ? r_slow : r_fast;
    assign w_acc_inc = ctl.acc_lo ? ACC_W'(w_p[LO_W+FRAC-1:FRAC])
                                  : {w_p[ACC_W-FRAC-1:0], {FRAC{1'b0}}};
    assign w_acc_new = w_acc_cur + w_acc_inc;

    // high-pass sum, arithmetic shift by 16 and clamp to 16 bits
    assign w_hp     = r_t + r_slow;
    assign w_hp_top = w_hp[ACC_W-1:OUT_W+FRAC-1];
    assign w_fits   = (&w_hp_top) || !(|w_hp_top);

    // low-pass: state moves by floor(diff / 2^mode)
    assign w_lp_step = r_diff >>> r_mode;
    assign w_lp_new  = r_lp + w_lp_step[LP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_coef <= FAST_COEF_RST;
            r_slow_coef <= SLOW_COEF_RST;
            r_gain      <= GAIN_RST;
            r_mode      <= LP_MODE_RST;
            r_fast      <= '0;
            r_slow      <= '0;
            r_lp        <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FAST_COEF: r_fast_coef <= i_cfg_data[COEF_W-1:0];
                    CFG_SLOW_COEF: r_slow_coef <= i_cfg_data[COEF_W-1:0];
                    CFG_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                    CFG_LP_MODE:   r_mode      <= i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (ctl.acc_lo || ctl.acc_hi) begin
                if (ctl.coef_slow) begin
                    r_slow <= w_acc_new;
                end else begin
                    r_fast <= w_acc_new;
                end
            end
            if (ctl.out_try && w_out_free) begin
                r_ov <= 1'b1;
                if (r_mode != LP_BYPASS) begin
                    r_lp <= w_lp_new;
                end
            end else if (o_smp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_smp  <= i_smp.sample_in;
            r_last <= i_smp.block_last;
        end
        if (ctl.d1) begin
            r_ino <= w_p_acc;
            r_d   <= w_p_acc - r_fast;
        end
        if (ctl.t_ino_slow) begin
            r_t <= r_ino - r_slow;
        end
        if (ctl.d2) begin
            r_d <= r_t - r_fast;
        end
        if (ctl.t_fast_ino) begin
            r_t <= r_fast - r_ino;
        end
        if (ctl.sat) begin
            r_y    <= w_fits ? w_hp[OUT_W+FRAC-1:FRAC] : (w_hp[ACC_W-1] ? Y_MIN : Y_MAX);
            r_clip <= !w_fits;
        end
        if (ctl.lpd) begin
            r_diff <= $signed({r_y[OUT_W-1], r_y, {FRAC{1'b0}}}) - $signed({r_lp[LP_W-1], r_lp});
        end
        if (ctl.out_try && w_out_free) begin
            r_osmp  <= (r_mode != LP_BYPASS) ? w_lp_new[LP_W-1:FRAC] : r_y;
            r_oclip <= r_clip;
            r_olast <= r_last;
        end
    end

    assign o_smp.valid      = r_ov;
    assign o_smp.sample_out = r_osmp;
    assign o_smp.clipped    = r_oclip;
    assign o_smp.last_out   = r_olast;

`ifndef SYNTH
    // a transfer starts a sample; no second transfer until it is done
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !i_smp.ready)
        else $error("input ready right after a transfer");

    // a clamped high-pass value is one of the two rails
    a_clip_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.sat |=> (!r_clip || r_y == Y_MAX || r_y == Y_MIN))
        else $error("clip flagged without rail value");

    // the output stage fills only from the last sequencer step
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_ov)) |-> $past(ctl.out_try))
        else $error("output valid without finished sample");

    // low-pass state moves only on output load with the low-pass enabled
    a_lp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_lp != $past(r_lp)) |->
            $past(ctl.out_try && w_out_free && r_mode != LP_BYPASS))
        else $error("low-pass state changed unexpectedly");
`endif

endmodule

// ----- rtl/ahlc_mul.sv -----
// Shared signed multiplier with registered product.
module ahlc_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [ahlc_pkg::MA_W-1:0]  i_a,
    input  logic signed [ahlc_pkg::MB_W-1:0]  i_b,
    output logic signed [ahlc_pkg::MP_W-1:0]  o_p
);
    import ahlc_pkg::*;

    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/ahlc_ctrl.sv -----
// Sequencer stepping one sample through the shared multiplier and adder.
module ahlc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_free,
    output logic            o_ready,
    output ahlc_pkg::t_ctl  o_ctl
);
    import ahlc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GAIN, ST_D1, ST_FLO, ST_FHI, ST_FADD, ST_D2,
        ST_SLO, ST_SHI, ST_SADD, ST_SAT, ST_LPD, ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_ctl   w_ctl;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = ST_GAIN;
            ST_GAIN: n_state = ST_D1;
            ST_D1:   n_state = ST_FLO;
            ST_FLO:  n_state = ST_FHI;
            ST_FHI:  n_state = ST_FADD;
            ST_FADD: n_state = ST_D2;
            ST_D2:   n_state = ST_SLO;
            ST_SLO:  n_state = ST_SHI;
            ST_SHI:  n_state = ST_SADD;
            ST_SADD: n_state = ST_SAT;
            ST_SAT:  n_state = ST_LPD;
            ST_LPD:  n_state = ST_OUT;
            ST_OUT:  if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl = '0;
        case (r_state)
            ST_GAIN: begin
                w_ctl.mul_en = 1'b1;
                w_ctl.mop    = MOP_GAIN;
            end
            ST_D1: w_ctl.d1 = 1'b1;
            ST_FLO: begin
                w_ctl.mul_en     = 1'b1;
                w_ctl.mop        = MOP_LO;
                w_ctl.t_ino_slow = 1'b1;
            end
            ST_FHI: begin
                w_ctl.mul_en = 1'b1;
                w_ctl.mop    = MOP_HI;
                w_ctl.acc_lo = 1'b1;
            end
            ST_FADD: w_ctl.acc_hi = 1'b1;
            ST_D2:   w_ctl.d2 = 1'b1;
            ST_SLO: begin
                w_ctl.mul_en     = 1'b1;
                w_ctl.mop        = MOP_LO;
                w_ctl.coef_slow  = 1'b1;
                w_ctl.t_fast_ino = 1'b1;
            end
            ST_SHI: begin
                w_ctl.mul_en    = 1'b1;
                w_ctl.mop       = MOP_HI;
                w_ctl.coef_slow = 1'b1;
                w_ctl.acc_lo    = 1'b1;
            end
            ST_SADD: begin
                w_ctl.coef_slow = 1'b1;
                w_ctl.acc_hi    = 1'b1;
            end
            ST_SAT:  w_ctl.sat = 1'b1;
            ST_LPD:  w_ctl.lpd = 1'b1;
            ST_OUT:  w_ctl.out_try = 1'b1;
            default: w_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_ctl   = w_ctl;

endmodule
